/* rtl/mpmsm_pkg.sv */
// Shared types and constants for the multi-period metal strength meter.
// Register map, phase encoding, output field widths and reset values.
// No dependencies.
package mpmsm_pkg;

    // Fixed field widths
    localparam int OUT_W      = 24;
    localparam int PERIOD_W   = 8;
    localparam int STRENGTH_W = 3;

    localparam int DEFAULT_COUNT_WIDTH = 24;

    // Register map (index = byte address / 4)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_COUNT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_LIMIT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_ONE_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_TWO_MAX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_THREE_MAX = 3'd4;

    // Register reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD_COUNT    = 8'd100;
    localparam logic [OUT_W-1:0]    RST_TIMEOUT_LIMIT   = 24'hffffff;
    localparam logic [OUT_W-1:0]    RST_LEVEL_ONE_MAX   = 24'd40;
    localparam logic [OUT_W-1:0]    RST_LEVEL_TWO_MAX   = 24'd100;
    localparam logic [OUT_W-1:0]    RST_LEVEL_THREE_MAX = 24'd200;

    // Strength codes
    localparam logic [STRENGTH_W-1:0] STRENGTH_ONE   = 3'd1;
    localparam logic [STRENGTH_W-1:0] STRENGTH_TWO   = 3'd2;
    localparam logic [STRENGTH_W-1:0] STRENGTH_THREE = 3'd3;
    localparam logic [STRENGTH_W-1:0] STRENGTH_FOUR  = 3'd4;

    // Measurement phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_WAIT_LOW   = 5'b00010,
        PH_WAIT_HIGH  = 5'b00100,
        PH_COUNT_LOW  = 5'b01000,
        PH_COUNT_HIGH = 5'b10000
    } phase_t;

    // Strength thresholds handed to the grading unit
    typedef struct packed {
        logic [OUT_W-1:0] level_one_max;
        logic [OUT_W-1:0] level_two_max;
        logic [OUT_W-1:0] level_three_max;
    } thresh_t;

    // Baseline bookkeeping handed to the grading unit
    typedef struct packed {
        logic             valid;
        logic             pending;
        logic [OUT_W-1:0] value;
    } base_t;

endpackage

/* rtl/multi_period_metal_strength_meter.sv */
// Top level of the multi-period metal strength meter: APB register file,
// phase sequencer, tick counter and output register.
// Depends on mpmsm_pkg and mpmsm_grade.
//
// Usage
//   Input stream (s_*): one request per tick of the counting clock, carrying
//   start_req, rebase and the sampled oscillator pin level. A start while idle
//   arms the block; it then waits for the pin low, then high, then times
//   period_count further rising edges. Each wait phase and the whole count time out at timeout_limit.
//   Output stream (m_*): at most one request per measurement with the tick
//   count (0 on timeout), timeout flag, baseline flag, absolute difference
//   from the baseline and a strength level of 1 to 4.
//   The result of the finishing tick appears on m_tvalid in the cycle after
//   that tick is accepted. Throughput: one input request every cycle while
//   s_tready is high; one pass of logic runs between the state registers
//   and the output register, so the output register is the only stage.
//   Stall: s_tready stays high while the output register is empty or being
//   drained; a stalled result holds in place and only then is input held off.
//   Reset (aresetn low, synchronous): registers return to their defaults,
//   phase goes idle, baseline is forgotten, the output register empties.
//   APB: five 32-bit registers at byte addresses 0,4,8,12,16; write them only
//   while no measurement is running.
module multi_period_metal_strength_meter
    import mpmsm_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] rebase, [2] pin_level, rest zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [23:0] period_ticks, [47:24] abs_difference,
                                   // [50:48] strength, rest zero
    output logic [1:0]  m_tuser    // [0] timed_out, [1] is_baseline
);

    localparam int WIDE_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] period_count_reg;
    logic [OUT_W-1:0]    timeout_limit_reg;
    thresh_t             thresh_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg           <= RST_PERIOD_COUNT;
            timeout_limit_reg          <= RST_TIMEOUT_LIMIT;
            thresh_reg.level_one_max   <= RST_LEVEL_ONE_MAX;
            thresh_reg.level_two_max   <= RST_LEVEL_TWO_MAX;
            thresh_reg.level_three_max <= RST_LEVEL_THREE_MAX;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_PERIOD_COUNT:    period_count_reg           <= pwdata[PERIOD_W-1:0];
                REG_TIMEOUT_LIMIT:   timeout_limit_reg          <= pwdata[OUT_W-1:0];
                REG_LEVEL_ONE_MAX:   thresh_reg.level_one_max   <= pwdata[OUT_W-1:0];
                REG_LEVEL_TWO_MAX:   thresh_reg.level_two_max   <= pwdata[OUT_W-1:0];
                REG_LEVEL_THREE_MAX: thresh_reg.level_three_max <= pwdata[OUT_W-1:0];
                default: ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PERIOD_COUNT:    prdata = {{(32-PERIOD_W){1'b0}}, period_count_reg};
            REG_TIMEOUT_LIMIT:   prdata = {{(32-OUT_W){1'b0}}, timeout_limit_reg};
            REG_LEVEL_ONE_MAX:   prdata = {{(32-OUT_W){1'b0}}, thresh_reg.level_one_max};
            REG_LEVEL_TWO_MAX:   prdata = {{(32-OUT_W){1'b0}}, thresh_reg.level_two_max};
            REG_LEVEL_THREE_MAX: prdata = {{(32-OUT_W){1'b0}}, thresh_reg.level_three_max};
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic in_fire;

    // take a new request whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    logic in_start;
    logic in_rebase;
    logic in_pin;

    assign in_start  = s_tdata[0];
    assign in_rebase = s_tdata[1];
    assign in_pin    = s_tdata[2];

    // ------------------------------------------------------------------
    // Measurement state
    // ------------------------------------------------------------------
    phase_t                 phase_reg,   phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg,    tick_next;
    logic [PERIOD_W-1:0]    edges_reg,   edges_next;
    base_t                  base_reg,    base_next;

    logic [COUNT_WIDTH-1:0] tick_bumped;
    logic [WIDE_W-1:0]      bumped_wide;
    logic [WIDE_W-1:0]      limit_wide;
    logic                   limit_hit;
    logic [PERIOD_W-1:0]    edges_inc;

    logic                   fin;
    logic                   fin_tout;
    logic [OUT_W-1:0]       fin_count;

    logic                   take;
    logic [OUT_W-1:0]       diff;
    logic [STRENGTH_W-1:0]  strength;

    always_comb begin
        // saturate at the counter's top value
        tick_bumped = (tick_reg == COUNT_MAX) ? tick_reg : tick_reg + 1'b1;
        bumped_wide = WIDE_W'(tick_bumped);
        // effective limit: smaller of the register and the counter's range
        if (WIDE_W'(timeout_limit_reg) < WIDE_W'(COUNT_MAX)) begin
            limit_wide = WIDE_W'(timeout_limit_reg);
        end else begin
            limit_wide = WIDE_W'(COUNT_MAX);
        end
        limit_hit = bumped_wide >= limit_wide;
        edges_inc = edges_reg + 1'b1;
    end

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        edges_next = edges_reg;
        base_next  = base_reg;
        fin        = 1'b0;
        fin_tout   = 1'b0;
        fin_count  = '0;

        unique case (phase_reg) inside
            PH_WAIT_LOW: begin
                if (!in_pin) begin
                    phase_next = PH_WAIT_HIGH;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_bumped;
                    if (limit_hit) begin
                        fin      = 1'b1;
                        fin_tout = 1'b1;
                    end
                end
            end
            PH_WAIT_HIGH: begin
                if (in_pin) begin
                    tick_next  = '0;
                    edges_next = '0;
                    if (period_count_reg == '0) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_COUNT_LOW;
                    end
                end else begin
                    tick_next = tick_bumped;
                    if (limit_hit) begin
                        fin      = 1'b1;
                        fin_tout = 1'b1;
                    end
                end
            end
            PH_COUNT_LOW, PH_COUNT_HIGH: begin
                tick_next = tick_bumped;
                if (phase_reg == PH_COUNT_LOW) begin
                    if (!in_pin) begin
                        phase_next = PH_COUNT_HIGH;
                    end
                end else if (in_pin) begin
                    edges_next = edges_inc;
                    if (edges_inc >= period_count_reg) begin
                        fin       = 1'b1;
                        fin_count = bumped_wide[OUT_W-1:0];
                    end else begin
                        phase_next = PH_COUNT_LOW;
                    end
                end
                // a completed count wins over a timeout on the same tick
                if (!fin && limit_hit) begin
                    fin      = 1'b1;
                    fin_tout = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (in_start) begin
                    phase_next       = PH_WAIT_LOW;
                    tick_next        = '0;
                    edges_next       = '0;
                    base_next.pending = in_rebase;
                end
            end
        endcase

        if (fin) begin
            phase_next        = PH_IDLE;
            tick_next         = '0;
            edges_next        = '0;
            base_next.pending = 1'b0;
            if (take) begin
                base_next.value = fin_count;
                base_next.valid = 1'b1;
            end
        end
    end

    mpmsm_grade u_grade (
        .count    (fin_count),
        .base     (base_reg),
        .thresh   (thresh_reg),
        .take     (take),
        .diff     (diff),
        .strength (strength)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            edges_reg <= '0;
            base_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            edges_reg <= edges_next;
            base_reg  <= base_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]      period_ticks_reg;
    logic [OUT_W-1:0]      abs_difference_reg;
    logic [STRENGTH_W-1:0] strength_reg;
    logic                  timed_out_reg;
    logic                  is_baseline_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire && fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload loads only when the register is free or draining
    always_ff @(posedge aclk) begin
        if (in_fire && fin) begin
            period_ticks_reg   <= fin_count;
            abs_difference_reg <= diff;
            strength_reg       <= strength;
            timed_out_reg      <= fin_tout;
            is_baseline_reg    <= take;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, strength_reg, abs_difference_reg, period_ticks_reg};
    assign m_tuser  = {is_baseline_reg, timed_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[23:0] == '0)
        else $error("timed-out result carries a nonzero count");

    a_baseline_grade: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[47:24] == '0 && m_tdata[50:48] == STRENGTH_ONE)
        else $error("baseline result is not graded as zero difference");

    a_strength_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[50:48] >= STRENGTH_ONE && m_tdata[50:48] <= STRENGTH_FOUR)
        else $error("strength out of range");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && fin |=> phase_reg == PH_IDLE && tick_reg == '0 && m_tvalid_reg
            && !base_reg.pending && base_reg.valid)
        else $error("finished measurement did not return to idle with a result");

endmodule

/* rtl/mpmsm_grade.sv */
// Grading unit: baseline take decision, absolute difference and strength level.
// Depends on mpmsm_pkg.
module mpmsm_grade
    import mpmsm_pkg::*;
(
    input  logic [OUT_W-1:0]      count,
    input  base_t                 base,
    input  thresh_t               thresh,
    output logic                  take,
    output logic [OUT_W-1:0]      diff,
    output logic [STRENGTH_W-1:0] strength
);

    logic [OUT_W-1:0] ref_value;

    always_comb begin
        take      = !base.valid || base.pending;
        // compare against the baseline as it stands after any update
        ref_value = take ? count : base.value;
        diff      = (count >= ref_value) ? (count - ref_value) : (ref_value - count);

        if (diff <= thresh.level_one_max) begin
            strength = STRENGTH_ONE;
        end else if (diff <= thresh.level_two_max) begin
            strength = STRENGTH_TWO;
        end else if (diff <= thresh.level_three_max) begin
            strength = STRENGTH_THREE;
        end else begin
            strength = STRENGTH_FOUR;
        end
    end

endmodule
